// ===== sv/sbce_pkg.sv =====
`timescale 1ns / 1ps
package sbce_pkg;

    localparam int REG_COUNT = 8;

    typedef logic [15:0] word_t;
    typedef logic [26:0] addr_t;

    // item kinds
    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_IRQ  = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_BAD_COND  = 3'd3;
    localparam logic [2:0] ST_BAD_OP    = 3'd4;
    localparam logic [2:0] ST_BAD_ITEM  = 3'd5;

    // opcodes
    localparam logic [3:0] OPC_PAGE = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_SUB  = 4'd2;
    localparam logic [3:0] OPC_AND  = 4'd3;
    localparam logic [3:0] OPC_OR   = 4'd4;
    localparam logic [3:0] OPC_NOT  = 4'd5;
    localparam logic [3:0] OPC_XOR  = 4'd6;
    localparam logic [3:0] OPC_SHL  = 4'd7;
    localparam logic [3:0] OPC_SHR  = 4'd8;
    localparam logic [3:0] OPC_LD   = 4'd9;
    localparam logic [3:0] OPC_ST   = 4'd10;
    localparam logic [3:0] OPC_JTGT = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_CALL = 4'd13;
    localparam logic [3:0] OPC_RET  = 4'd14;
    localparam logic [3:0] OPC_BAD  = 4'd15;

    // jump conditions {M, Dest}
    localparam logic [3:0] CND_NEVER = 4'd0;
    localparam logic [3:0] CND_ULT   = 4'd1;
    localparam logic [3:0] CND_UEQ   = 4'd2;
    localparam logic [3:0] CND_ULE   = 4'd3;
    localparam logic [3:0] CND_UGT   = 4'd4;
    localparam logic [3:0] CND_UNE   = 4'd5;
    localparam logic [3:0] CND_UGE   = 4'd6;
    localparam logic [3:0] CND_ALWAYS = 4'd7;
    localparam logic [3:0] CND_SLT   = 4'd8;
    localparam logic [3:0] CND_SEQ   = 4'd9;
    localparam logic [3:0] CND_SLE   = 4'd10;
    localparam logic [3:0] CND_SGT   = 4'd11;
    localparam logic [3:0] CND_SNE   = 4'd12;
    localparam logic [3:0] CND_SGE   = 4'd13;

    typedef struct packed {
        logic [1:0] operation;
        word_t      instruction;
        word_t      imm_first;
        word_t      imm_second;
        word_t      load_data;
    } in_item_t;

    typedef struct packed {
        addr_t      fetch_address;
        logic       mem_read;
        logic       mem_write;
        addr_t      mem_address;
        word_t      mem_data;
        logic [2:0] status;
    } out_item_t;

endpackage

// ===== sv/sbce_in_if.sv =====
`timescale 1ns / 1ps
interface sbce_in_if;
    logic               valid;
    logic               ready;
    sbce_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sbce_out_if.sv =====
`timescale 1ns / 1ps
interface sbce_out_if;
    logic                valid;
    logic                ready;
    sbce_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sixteen_bit_cpu_execute_step.sv =====
`timescale 1ns / 1ps
// Channel   Role   Payload                                     Accepted when
// request   sink   operation, instruction, imm_first/second,   valid && ready
//                  load_data
// result    source fetch_address, mem_read/write, mem_address, valid && ready
//                  mem_data, status
//
// One item per cycle: each item is decoded, executed and its state updated in
// the cycle it is accepted; the result register holds its result. The rate is
// set by the combinational execute path (register read, ALU/compare, PC add).
// Reset clears all architectural state at once; the return stack needs no
// clearing. A stalled result holds and blocks the next item only while the
// result register is full and not taken.
module sixteen_bit_cpu_execute_step #(
    parameter int STACK_DEPTH = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    sbce_in_if.sink    request,
    sbce_out_if.source result
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

    // architectural state
    sbce_pkg::word_t regs_reg [sbce_pkg::REG_COUNT];
    logic [15:0]     pc_reg;
    logic [10:0]     cpage_reg, dpage_reg;
    sbce_pkg::addr_t jtgt_reg, ivec_reg;
    logic            masked_reg;
    logic [CW-1:0]   cnt_reg;
    logic            lpend_reg;
    logic [2:0]      ldest_reg;
    logic [1:0]      llen_reg;

    // return stack: top entry and the one below live in registers,
    // deeper entries in the memory
    sbce_pkg::addr_t stk_mem [STACK_DEPTH];
    sbce_pkg::addr_t top_reg, below_reg;

    logic                out_valid_reg;
    sbce_pkg::out_item_t out_reg;

    logic accept;
    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;

    // decode
    sbce_pkg::in_item_t it;
    logic [3:0]  opc;
    logic        m, lx, ly;
    logic [2:0]  dest, sx, sy;
    logic [1:0]  len;
    sbce_pkg::word_t x, y, ym, r;
    logic [3:0]  sh, cnd;
    logic        cond_ok;
    sbce_pkg::addr_t cur_addr, adv_addr, dmem_addr;

    assign it   = request.data;
    assign opc  = it.instruction[15:12];
    assign m    = it.instruction[11];
    assign dest = it.instruction[10:8];
    assign lx   = it.instruction[7];
    assign sx   = it.instruction[6:4];
    assign ly   = it.instruction[3];
    assign sy   = it.instruction[2:0];
    assign len  = 2'd1 + {1'b0, lx} + {1'b0, ly};
    assign x    = lx ? it.imm_first : regs_reg[sx];
    assign y    = (lx && ly) ? it.imm_second : (ly ? it.imm_first : regs_reg[sy]);
    assign ym   = m ? ~y : y;
    assign sh   = y[3:0];
    assign cnd  = {m, dest};
    assign cur_addr  = {cpage_reg, pc_reg};
    assign dmem_addr = {dpage_reg, x};

    // control decisions passed to the state update
    typedef struct packed {
        logic            wr_reg;
        logic [2:0]      wr_idx;
        sbce_pkg::word_t wr_val;
        logic            set_pc;
        sbce_pkg::addr_t pc_val;
        logic            push;
        sbce_pkg::addr_t push_val;
        logic            pop;
    } ctl_t;
    ctl_t ctl;
    sbce_pkg::out_item_t res;

    always_comb
    begin
        logic [31:0] rl;
        logic [31:0] rr;
        rl = {x, x} << sh;
        rr = {x, x} >> sh;
        unique case (opc)
            sbce_pkg::OPC_ADD:  r = x + y + {15'd0, m};
            sbce_pkg::OPC_SUB:  r = x - y - {15'd0, m};
            sbce_pkg::OPC_AND:  r = x & ym;
            sbce_pkg::OPC_OR:   r = x | ym;
            sbce_pkg::OPC_NOT:  r = ~x + {15'd0, m};
            sbce_pkg::OPC_XOR:  r = x ^ ym;
            sbce_pkg::OPC_SHL:  r = m ? rl[31:16] : (x << sh);
            sbce_pkg::OPC_SHR:  r = m ? rr[15:0] : sbce_pkg::word_t'($signed(x) >>> sh);
            default:            r = x + 16'd1;   // post-increment
        endcase
    end

    always_comb
    begin
        unique case (cnd)
            sbce_pkg::CND_ULT:    cond_ok = x < y;
            sbce_pkg::CND_UEQ:    cond_ok = x == y;
            sbce_pkg::CND_ULE:    cond_ok = x <= y;
            sbce_pkg::CND_UGT:    cond_ok = x > y;
            sbce_pkg::CND_UNE:    cond_ok = x != y;
            sbce_pkg::CND_UGE:    cond_ok = x >= y;
            sbce_pkg::CND_ALWAYS: cond_ok = 1'b1;
            sbce_pkg::CND_SLT:    cond_ok = $signed(x) < $signed(y);
            sbce_pkg::CND_SEQ:    cond_ok = x == y;
            sbce_pkg::CND_SLE:    cond_ok = $signed(x) <= $signed(y);
            sbce_pkg::CND_SGT:    cond_ok = $signed(x) > $signed(y);
            sbce_pkg::CND_SNE:    cond_ok = x != y;
            sbce_pkg::CND_SGE:    cond_ok = $signed(x) >= $signed(y);
            default:              cond_ok = 1'b0;
        endcase
    end

    logic stk_full;
    assign stk_full = cnt_reg >= CW'(STACK_DEPTH);

    always_comb
    begin
        logic [1:0] adv_n;
        logic       do_adv;
        ctl    = '0;
        res    = '0;
        do_adv = 1'b0;
        adv_n  = len;
        if (it.operation == sbce_pkg::OP_LOAD && lpend_reg)
        begin
            ctl.wr_reg = 1'b1;
            ctl.wr_idx = ldest_reg;
            ctl.wr_val = it.load_data;
            do_adv     = 1'b1;
            adv_n      = llen_reg;
        end
        else if ((it.operation != sbce_pkg::OP_EXEC && it.operation != sbce_pkg::OP_IRQ)
                 || lpend_reg)
        begin
            res.status = sbce_pkg::ST_BAD_ITEM;
        end
        else if (it.operation == sbce_pkg::OP_IRQ)
        begin
            if (!masked_reg)
            begin
                if (stk_full)
                    res.status = sbce_pkg::ST_OVERFLOW;
                else
                begin
                    ctl.push     = 1'b1;
                    ctl.push_val = cur_addr;
                    ctl.set_pc   = 1'b1;
                    ctl.pc_val   = ivec_reg;
                end
            end
        end
        else
        begin
            unique case (opc)
                sbce_pkg::OPC_ADD, sbce_pkg::OPC_SUB, sbce_pkg::OPC_AND,
                sbce_pkg::OPC_OR, sbce_pkg::OPC_NOT, sbce_pkg::OPC_XOR,
                sbce_pkg::OPC_SHL, sbce_pkg::OPC_SHR:
                begin
                    ctl.wr_reg = 1'b1;
                    ctl.wr_idx = dest;
                    ctl.wr_val = r;
                    do_adv     = 1'b1;
                end
                sbce_pkg::OPC_LD, sbce_pkg::OPC_ST:
                begin
                    res.mem_address = dmem_addr;
                    res.mem_read    = opc == sbce_pkg::OPC_LD;
                    res.mem_write   = opc == sbce_pkg::OPC_ST;
                    res.mem_data    = (opc == sbce_pkg::OPC_ST) ? y : 16'd0;
                    ctl.wr_reg      = m && !lx;
                    ctl.wr_idx      = sx;
                    ctl.wr_val      = r;
                    do_adv          = opc == sbce_pkg::OPC_ST;
                end
                sbce_pkg::OPC_PAGE, sbce_pkg::OPC_JTGT:
                    do_adv = 1'b1;
                sbce_pkg::OPC_JMP:
                begin
                    if (cnd >= 4'd14)
                        res.status = sbce_pkg::ST_BAD_COND;
                    else if (cond_ok)
                    begin
                        ctl.set_pc = 1'b1;
                        ctl.pc_val = jtgt_reg;
                    end
                    else
                        do_adv = 1'b1;
                end
                sbce_pkg::OPC_CALL:
                begin
                    if (stk_full)
                        res.status = sbce_pkg::ST_OVERFLOW;
                    else
                    begin
                        ctl.push     = 1'b1;
                        ctl.push_val = cur_addr + {25'd0, len};
                        ctl.set_pc   = 1'b1;
                        ctl.pc_val   = {m ? cpage_reg : dpage_reg, x};
                    end
                end
                sbce_pkg::OPC_RET:
                begin
                    if (cnt_reg == '0)
                        res.status = sbce_pkg::ST_UNDERFLOW;
                    else
                    begin
                        ctl.pop    = 1'b1;
                        ctl.set_pc = 1'b1;
                        ctl.pc_val = top_reg;
                    end
                end
                default:
                    res.status = sbce_pkg::ST_BAD_OP;
            endcase
        end
        adv_addr = cur_addr + {25'd0, adv_n};
        if (do_adv)
        begin
            ctl.set_pc = 1'b1;
            ctl.pc_val = adv_addr;
        end
        res.fetch_address = ctl.set_pc ? ctl.pc_val : cur_addr;
    end

    logic is_exec;
    assign is_exec = it.operation == sbce_pkg::OP_EXEC && !lpend_reg;

    // architectural state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbce_pkg::REG_COUNT; i++)
                regs_reg[i] <= '0;
            pc_reg     <= '0;
            cpage_reg  <= '0;
            dpage_reg  <= '0;
            jtgt_reg   <= '0;
            ivec_reg   <= '0;
            masked_reg <= 1'b0;
            cnt_reg    <= '0;
            lpend_reg  <= 1'b0;
            ldest_reg  <= '0;
            llen_reg   <= '0;
        end
        else if (accept)
        begin
            if (ctl.wr_reg)
                regs_reg[ctl.wr_idx] <= ctl.wr_val;
            if (ctl.set_pc)
                {cpage_reg, pc_reg} <= ctl.pc_val;
            if (ctl.push)
                cnt_reg <= cnt_reg + 1'b1;
            if (ctl.pop)
            begin
                cnt_reg    <= cnt_reg - 1'b1;
                masked_reg <= m;
            end
            if (ctl.push && it.operation == sbce_pkg::OP_IRQ)
                masked_reg <= 1'b1;
            if (it.operation == sbce_pkg::OP_LOAD && lpend_reg)
                lpend_reg <= 1'b0;
            if (is_exec)
            begin
                unique case (opc)
                    sbce_pkg::OPC_PAGE:
                        if (m)
                            ivec_reg <= dmem_addr;
                        else
                            dpage_reg <= x[10:0];
                    sbce_pkg::OPC_JTGT:
                        if (m)
                            jtgt_reg[15:0] <= x;
                        else
                            jtgt_reg <= dmem_addr;
                    sbce_pkg::OPC_LD:
                    begin
                        lpend_reg <= 1'b1;
                        ldest_reg <= dest;
                        llen_reg  <= len;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // return stack: push spills the top to memory, pop refills from below
    logic [CW-1:0] cnt_m1, cnt_m3;
    assign cnt_m1 = cnt_reg - CW'(1);
    assign cnt_m3 = cnt_reg - CW'(3);

    always_ff @(posedge clk)
    begin
        if (accept && ctl.push)
        begin
            if (cnt_reg != '0)
                stk_mem[cnt_m1[AW-1:0]] <= top_reg;
            below_reg <= top_reg;
            top_reg   <= ctl.push_val;
        end
        else if (accept && ctl.pop)
        begin
            top_reg   <= below_reg;
            below_reg <= stk_mem[cnt_m3[AW-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res;
    end

endmodule

// ===== sv/sbce_checker.sv =====
`timescale 1ns / 1ps
module sbce_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input sbce_pkg::out_item_t out_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no request both ways
    a_rw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.mem_read && out_data.mem_write))
        else $error("read and write together");

    // errors issue no memory request
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != sbce_pkg::ST_OK
        |-> !out_data.mem_read && !out_data.mem_write && out_data.mem_address == '0)
        else $error("memory request with error status");

    // store data only on a write
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.mem_write |-> out_data.mem_data == '0)
        else $error("store data without write");
endmodule

bind sixteen_bit_cpu_execute_step sbce_checker u_sbce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
